// ===== rtl/core/bhd_pkg.sv =====
// Shared types and constants of the byte 4-gram hash dedup block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package bhd_pkg;

   localparam int TABLE_SIZE_DEF = 1000081;
   localparam int LIST_DEPTH_DEF = 32768;

   localparam int DATA_W       = 8;
   localparam int INDEX_W      = 20;
   localparam int RSP_TDATA_W  = 24;
   localparam int LIMIT_W      = 16;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int GRAM_LEN     = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd30000;
   localparam logic [31:0]        SPACES_WINDOW = 32'h2020_2020;

   localparam logic [CSR_ADDR_W-3:0] REG_BYTE_LIMIT = '0;

   typedef struct packed {
      logic init_step;
      logic accept;
      logic mul_hi;
      logic mul_lo;
      logic reduce;
      logic read;
      logic check;
      logic emit;
      logic clear_step;
      logic clear_end;
   } cmd_type;

   typedef struct packed {
      logic init_done;
      logic will_probe;
      logic has_result;
      logic rsp_free;
      logic last;
      logic clear_done;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/bhd_ctrl.sv =====
// Controller of the byte 4-gram hash dedup block: sequences reset clearing,
// the per-byte hash and bitmap probe, result hand-off and end-of-message clearing.
// Depends on bhd_pkg.
`default_nettype none

module bhd_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  bhd_pkg::status_type     status,
   output bhd_pkg::cmd_type        cmd
);
   import bhd_pkg::*;

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_MUL_HI = 4'd2;
   localparam logic [3:0] ST_MUL_LO = 4'd3;
   localparam logic [3:0] ST_REDUCE = 4'd4;
   localparam logic [3:0] ST_READ   = 4'd5;
   localparam logic [3:0] ST_CHECK  = 4'd6;
   localparam logic [3:0] ST_EMIT   = 4'd7;
   localparam logic [3:0] ST_CLEAR  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (status.init_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = status.will_probe ? ST_MUL_HI : ST_EMIT;
            end
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.has_result) begin
               state_in = ST_IDLE;
            end else if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = status.last ? ST_CLEAR : ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               cmd.clear_end = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/bhd_datapath.sv =====
// Datapath of the byte 4-gram hash dedup block: byte window, modulo reduction,
// presence bitmap, touched list and result register. Depends on bhd_pkg.
`default_nettype none

module bhd_datapath #(
   parameter int TABLE_SIZE = bhd_pkg::TABLE_SIZE_DEF,
   parameter int LIST_DEPTH = bhd_pkg::LIST_DEPTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  bhd_pkg::cmd_type                    cmd,
   output bhd_pkg::status_type                 status,
   input  wire [bhd_pkg::LIMIT_W-1:0]          byte_limit,
   input  wire [bhd_pkg::DATA_W-1:0]           req_tdata,   // data_byte
   input  wire                                 req_tlast,   // last_byte
   input  wire                                 rsp_tready,
   output logic                                rsp_tvalid,
   output logic [bhd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // feature_index, zero pad
   output logic                                rsp_tlast    // message_end
);
   import bhd_pkg::*;

   localparam int BUCKET_W    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int LIST_ADDR_W = $clog2(LIST_DEPTH);
   localparam int COUNT_W     = $clog2(LIST_DEPTH + 1);
   localparam int SEEN_W      = $clog2(LIST_DEPTH + 1);

   localparam logic [63:0] RECIP64       = 64'h1_0000_0000 / 64'(TABLE_SIZE);
   localparam logic [31:0] RECIP         = RECIP64[31:0];
   localparam logic [31:0] TSIZE32       = 32'(TABLE_SIZE);
   localparam logic [31:0] DEPTH32       = 32'(LIST_DEPTH);
   localparam logic [31:0] SPACES_FEAT32 = (SPACES_WINDOW % TSIZE32) + 32'd1;
   localparam logic [INDEX_W-1:0] SPACES_FEAT = SPACES_FEAT32[INDEX_W-1:0];
   localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(TABLE_SIZE - 1);

   logic bitmap_mem [TABLE_SIZE];
   logic [BUCKET_W-1:0] list_mem [LIST_DEPTH];

   logic [31:0]          window_ff;
   logic [SEEN_W-1:0]    bytes_seen_ff;
   logic                 last_ff;
   logic [31:0]          q_ff;
   logic [31:0]          qt_ff;
   logic [BUCKET_W-1:0]  bucket_ff;
   logic                 bit_q_ff;
   logic                 new_ff;
   logic [INDEX_W-1:0]   feat_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   clr_idx_ff;
   logic                 pend_ff;
   logic [BUCKET_W-1:0]  list_q_ff;
   logic [BUCKET_W-1:0]  init_addr_ff;
   logic                 rsp_valid_ff;
   logic [INDEX_W-1:0]   rsp_feat_ff;
   logic                 rsp_last_ff;

   logic [31:0]          eff_limit;
   logic                 used;
   logic [63:0]          prod;
   logic [31:0]          qt;
   logic [31:0]          rem;
   logic [31:0]          rem_sub;
   logic [31:0]          feat32;
   logic                 is_new;
   logic                 short_msg;
   logic                 bm_we;
   logic [BUCKET_W-1:0]  bm_waddr;
   logic                 bm_wdata;

   assign eff_limit = (32'(byte_limit) > DEPTH32) ? DEPTH32 : 32'(byte_limit);
   assign used      = 32'(bytes_seen_ff) < eff_limit;
   assign prod      = 64'(window_ff) * 64'(RECIP);
   assign qt        = q_ff * TSIZE32;
   assign rem       = window_ff - qt_ff;
   assign rem_sub   = rem - TSIZE32;
   assign feat32    = 32'(bucket_ff) + 32'd1;
   assign is_new    = !bit_q_ff;
   assign short_msg = 32'(bytes_seen_ff) < 32'(GRAM_LEN);

   always_comb begin
      status            = '0;
      status.init_done  = (init_addr_ff == LAST_BUCKET);
      status.will_probe = used && ((32'(bytes_seen_ff) + 32'd1) >= 32'(GRAM_LEN));
      status.has_result = last_ff || new_ff;
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
      status.last       = last_ff;
      status.clear_done = (clr_idx_ff == count_ff) && !pend_ff;
   end

   // window, counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         bytes_seen_ff <= '0;
         last_ff       <= 1'b0;
         new_ff        <= 1'b0;
         count_ff      <= '0;
         clr_idx_ff    <= '0;
         pend_ff       <= 1'b0;
         init_addr_ff  <= '0;
      end else begin
         if (cmd.init_step && !status.init_done) begin
            init_addr_ff <= init_addr_ff + BUCKET_W'(1);
         end
         if (cmd.accept) begin
            last_ff <= req_tlast;
            new_ff  <= 1'b0;
            if (used) begin
               window_ff     <= {window_ff[23:0], req_tdata};
               bytes_seen_ff <= bytes_seen_ff + SEEN_W'(1);
            end
         end
         if (cmd.check) begin
            new_ff <= is_new;
            if (is_new) begin
               count_ff <= count_ff + COUNT_W'(1);
            end
         end
         if (cmd.emit && last_ff) begin
            window_ff     <= '0;
            bytes_seen_ff <= '0;
         end
         if (cmd.clear_end) begin
            count_ff   <= '0;
            clr_idx_ff <= '0;
            pend_ff    <= 1'b0;
         end else if (cmd.clear_step) begin
            if (clr_idx_ff != count_ff) begin
               clr_idx_ff <= clr_idx_ff + COUNT_W'(1);
               pend_ff    <= 1'b1;
            end else begin
               pend_ff <= 1'b0;
            end
         end
      end
   end

   // modulo reduction by reciprocal, at most one multiply per stage
   always_ff @(posedge clock) begin
      if (cmd.mul_hi) begin
         q_ff <= prod[63:32];
      end
      if (cmd.mul_lo) begin
         qt_ff <= qt;
      end
      if (cmd.reduce) begin
         bucket_ff <= (rem >= TSIZE32) ? rem_sub[BUCKET_W-1:0] : rem[BUCKET_W-1:0];
      end
      if (cmd.accept) begin
         feat_ff <= '0;
      end else if (cmd.check) begin
         feat_ff <= is_new ? feat32[INDEX_W-1:0] : '0;
      end
   end

   // presence bitmap
   always_comb begin
      bm_we    = 1'b0;
      bm_waddr = '0;
      bm_wdata = 1'b0;
      if (cmd.init_step) begin
         bm_we    = 1'b1;
         bm_waddr = init_addr_ff;
      end else if (cmd.check && is_new) begin
         bm_we    = 1'b1;
         bm_waddr = bucket_ff;
         bm_wdata = 1'b1;
      end else if (pend_ff) begin
         bm_we    = 1'b1;
         bm_waddr = list_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem[bm_waddr] <= bm_wdata;
      end
      if (cmd.read) begin
         bit_q_ff <= bitmap_mem[bucket_ff];
      end
   end

   // touched list
   always_ff @(posedge clock) begin
      if (cmd.check && is_new) begin
         list_mem[count_ff[LIST_ADDR_W-1:0]] <= bucket_ff;
      end
      if (cmd.clear_step && (clr_idx_ff != count_ff)) begin
         list_q_ff <= list_mem[clr_idx_ff[LIST_ADDR_W-1:0]];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_feat_ff <= (last_ff && short_msg) ? SPACES_FEAT : feat_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - INDEX_W){1'b0}}, rsp_feat_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result issued while output register is occupied");

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.check |-> $past(cmd.read))
      else $error("bitmap check without a preceding read");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      32'(bytes_seen_ff) <= DEPTH32)
      else $error("byte count past list depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) < DEPTH32)
      else $error("touched list overflow");

   a_pend_in_clear: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.clear_step))
      else $error("clear write without a list read");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/byte_4gram_hash_dedup.sv =====
// Hashed byte 4-gram feature extractor with per-message dedup. Each request is one
// message byte; from the fourth used byte on, the last four bytes form a 32-bit window
// reduced modulo TABLE_SIZE to a bucket, and a bucket not yet seen in this message is
// returned as feature index bucket+1. A byte that finds no new bucket gives no result;
// the final byte always gives one result with tlast set (index 0 if nothing new, or the
// four-space window's index for a message shorter than four used bytes). A byte that is
// probed passes through accept, reciprocal multiply, constant multiply, correction,
// bitmap read, bitmap update and hand-off; a byte that is not probed goes from accept
// straight to hand-off. A result also holds the byte for as long as the output register
// stays full. At the end of a message the touched list is walked to clear the bitmap.
// After reset the bitmap is swept clear, one bucket a cycle, over all TABLE_SIZE
// buckets (1000081 by default) before the first request is taken; CSR writes are
// taken meanwhile.
// Depends on bhd_pkg, bhd_ctrl and bhd_datapath.
`default_nettype none

module byte_4gram_hash_dedup #(
   parameter int TABLE_SIZE = bhd_pkg::TABLE_SIZE_DEF,
   parameter int LIST_DEPTH = bhd_pkg::LIST_DEPTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [bhd_pkg::DATA_W-1:0]           req_tdata,   // data_byte
   input  wire                                 req_tlast,   // last_byte
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [bhd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // feature_index, zero pad
   output logic                                rsp_tlast,   // message_end
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [bhd_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire [bhd_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [bhd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import bhd_pkg::*;

   logic [LIMIT_W-1:0] byte_limit_ff;
   logic               sel_limit;
   cmd_type            cmd;
   status_type         status;

   assign csr_pready = 1'b1;
   assign sel_limit  = (csr_paddr[CSR_ADDR_W-1:2] == REG_BYTE_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_limit) begin
         byte_limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_prdata = sel_limit ? {{(CSR_DATA_W - LIMIT_W){1'b0}}, byte_limit_ff} : '0;

   bhd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bhd_datapath #(
      .TABLE_SIZE (TABLE_SIZE),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .byte_limit (byte_limit_ff),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
